[hdl/ccc_pkg.sv]
// Package for the conductivity compensation and calibration block.
// Holds shared types, command and status codes, and fixed-point constants.
// No dependencies.
package ccc_pkg;

	localparam int unsigned KW = 24;
	localparam int unsigned PRESET_W = 23;
	localparam int unsigned VW = 16;
	localparam int unsigned TW = 12;
	localparam int unsigned DW = 17;
	localparam int unsigned CONDW = 24;
	localparam int unsigned NUMW = 64;
	localparam int unsigned QW = 40;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned K_RESET = 65536;

	localparam logic [CFG_IDX_W-1:0] REG_K_LOW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_K_HIGH = 1'd1;

	localparam logic [1:0] CMD_MEASURE = 2'd0;
	localparam logic [1:0] CMD_ENTER = 2'd1;
	localparam logic [1:0] CMD_EXIT = 2'd2;
	localparam logic [1:0] CMD_CAL = 2'd3;

	localparam logic [2:0] ST_MEASURED = 3'd0;
	localparam logic [2:0] ST_ENTERED = 3'd1;
	localparam logic [2:0] ST_SAVED = 3'd2;
	localparam logic [2:0] ST_EXIT_IDLE = 3'd3;
	localparam logic [2:0] ST_LOW_BUF = 3'd4;
	localparam logic [2:0] ST_HIGH_BUF = 3'd5;
	localparam logic [2:0] ST_UNKNOWN_BUF = 3'd6;
	localparam logic [2:0] ST_NOT_CAL = 3'd7;

	localparam logic [63:0] RANGE_LIMIT = 64'd343932928;
	localparam logic [63:0] LOW_WIN_LO = 64'd75571200;
	localparam logic [63:0] LOW_WIN_HI = 64'd159539200;
	localparam logic [63:0] HIGH_WIN_LO = 64'd755712000;
	localparam logic [63:0] HIGH_WIN_HI = 64'd1410662400;

	// Datapath operation selected by the controller.
	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_MEAS = 2'd1,
		OP_CAL_LOW = 2'd2,
		OP_CAL_HIGH = 2'd3
	} op_t;

	typedef struct packed {
		logic start;
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic high;
		logic in_low_win;
		logic in_high_win;
		logic [KW-1:0] result;
	} dp_sts_t;

endpackage

[hdl/ccc_divider.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on ccc_pkg for widths.
module ccc_divider (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [ccc_pkg::NUMW-1:0] num,
	input  logic [ccc_pkg::QW-1:0]   den,
	output logic                    done,
	output logic [ccc_pkg::NUMW-1:0] quo
);
	import ccc_pkg::*;

	logic [NUMW-1:0] quo_q;
	logic [QW:0] rem_q;
	logic [QW-1:0] den_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic [QW:0] trial;
	logic [QW:0] diff;

	assign trial = {rem_q[QW-1:0], quo_q[NUMW-1]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(NUMW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[QW]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NUMW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUMW-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
endmodule

[hdl/ccc_datapath.sv]
// Datapath: temperature denominator, range choice, windows and the
// rounded divisions. Depends on ccc_pkg and ccc_divider.
module ccc_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ccc_pkg::dp_cmd_t       cmd,
	input  logic [ccc_pkg::VW-1:0] voltage,
	input  logic [ccc_pkg::TW-1:0] temp,
	input  logic [ccc_pkg::KW-1:0] k_low,
	input  logic [ccc_pkg::KW-1:0] k_high,
	output ccc_pkg::dp_sts_t       sts
);
	import ccc_pkg::*;

	typedef enum logic [3:0] {
		P_IDLE = 4'b0001,
		P_MUL1 = 4'b0010,
		P_MUL2 = 4'b0100,
		P_DIV  = 4'b1000
	} pst_t;

	pst_t st_q;
	op_t op_q;
	logic signed [TW-1:0] tc;
	logic [DW-1:0] d_comb;
	logic [DW-1:0] d_q;
	logic [VW-1:0] v_q;
	logic [KW-1:0] k_q;
	logic [47:0] vk_q;
	logic [NUMW-1:0] num_q;
	logic [QW-1:0] den_q;
	logic div_go_q;
	logic div_done;
	logic [NUMW-1:0] quo;
	logic [39:0] vd_comb;
	logic signed [TW+7:0] dprod;
	logic use_high;
	logic done_q;
	logic high_q;
	logic low_win_q;
	logic high_win_q;
	logic [KW-1:0] result_q;

	always_comb begin
		tc = $signed(temp);
		if ($signed(temp) < -12'sd320) tc = -12'sd320;
		if ($signed(temp) > 12'sd1600) tc = 12'sd1600;
		dprod = 20'sd32000 + 20'sd37 * (20'(tc) - 20'sd400);
		d_comb = dprod[DW-1:0];
	end

	assign vd_comb = 40'(voltage) * 40'(d_comb);
	assign use_high = 48'(voltage) * 48'(k_low) > 48'(RANGE_LIMIT);

	// The divider start is registered, so the divider starts in the cycle after the numerator is registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= P_IDLE;
			div_go_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			div_go_q <= (st_q == P_MUL2);
			done_q <= (st_q == P_DIV) && div_done;
			unique case (st_q)
				P_IDLE: if (cmd.start && cmd.op != OP_NONE) st_q <= P_MUL1;
				P_MUL1: st_q <= P_MUL2;
				P_MUL2: st_q <= P_DIV;
				P_DIV: if (div_done) st_q <= P_IDLE;
				default: st_q <= P_IDLE;
			endcase
		end
	end

	// Window and range flags settle on start; divisions follow.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= cmd.op;
			d_q <= d_comb;
			v_q <= voltage;
			high_q <= use_high;
			low_win_q <= 64'(vd_comb) > LOW_WIN_LO && 64'(vd_comb) < LOW_WIN_HI;
			high_win_q <= 64'(vd_comb) > HIGH_WIN_LO && 64'(vd_comb) < HIGH_WIN_HI;
			k_q <= use_high ? k_high : k_low;
		end
		if (st_q == P_MUL1) begin
			if (op_q == OP_MEAS) begin
				vk_q <= 48'(v_q) * 48'(k_q);
				den_q <= 40'(d_q) * 40'd2686976;
			end else begin
				vk_q <= 48'(d_q) * ((op_q == OP_CAL_LOW) ? 48'd118646784 : 48'd1081507840);
				den_q <= 40'(v_q) * 40'd15625;
			end
		end
		if (st_q == P_MUL2) begin
			if (op_q == OP_MEAS)
				num_q <= 64'(vk_q) * 64'd500000 + 64'(den_q >> 1);
			else
				num_q <= 64'(vk_q) + 64'(den_q >> 1);
		end
		if (div_done)
			result_q <= (quo > 64'hFFFFFF) ? 24'hFFFFFF : quo[KW-1:0];
	end

	assign sts = '{done: done_q, high: high_q, in_low_win: low_win_q,
		in_high_win: high_win_q, result: result_q};

	ccc_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q),
		.num(num_q), .den(den_q), .done(div_done), .quo(quo)
	);
endmodule

[hdl/ccc_ctrl.sv]
// Controller: command sequencing, calibration state and constants.
// Depends on ccc_pkg; drives ccc_datapath through dp_cmd_t.
module ccc_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ccc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ccc_pkg::PRESET_W-1:0] cfg_data,
	input  logic                         in_fire,
	input  logic [1:0]                   in_cmd,
	output logic                         busy,
	output ccc_pkg::dp_cmd_t             dcmd,
	input  ccc_pkg::dp_sts_t             dsts,
	output logic                         res_valid,
	output logic [ccc_pkg::CONDW-1:0]    res_cond,
	output logic [2:0]                   res_status,
	output logic                         res_high,
	output logic                         res_cal,
	output logic [ccc_pkg::KW-1:0]       k_low,
	output logic [ccc_pkg::KW-1:0]       k_high,
	input  logic                         out_free
);
	import ccc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_WAIT = 5'b00010,
		S_CHECK = 5'b00100,
		S_CALDIV = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t st_q;
	logic [1:0] cmd_q;
	logic [KW-1:0] pend_low_q, pend_high_q;
	logic cal_q;
	logic cal_go;

	assign busy = (st_q != S_IDLE);

	// A calibrate item in calibration mode inside a buffer window launches the constant division.
	assign cal_go = (st_q == S_CHECK) && (cmd_q == CMD_CAL) && cal_q
		&& (dsts.in_low_win || dsts.in_high_win);

	always_comb begin
		dcmd.start = in_fire || cal_go;
		if (cal_go)
			dcmd.op = dsts.in_low_win ? OP_CAL_LOW : OP_CAL_HIGH;
		else if (in_cmd == CMD_MEASURE)
			dcmd.op = OP_MEAS;
		else
			dcmd.op = OP_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			k_low <= KW'(K_RESET);
			k_high <= KW'(K_RESET);
			pend_low_q <= KW'(K_RESET);
			pend_high_q <= KW'(K_RESET);
			cal_q <= 1'b0;
			res_valid <= 1'b0;
			cmd_q <= CMD_MEASURE;
			res_cond <= '0;
			res_status <= ST_MEASURED;
			res_high <= 1'b0;
			res_cal <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_K_LOW: k_low <= KW'(cfg_data);
					REG_K_HIGH: k_high <= KW'(cfg_data);
					default: ;
				endcase
			end
			unique case (st_q)
				S_IDLE: if (in_fire) begin
					cmd_q <= in_cmd;
					st_q <= (in_cmd == CMD_MEASURE) ? S_WAIT : S_CHECK;
				end
				S_WAIT: if (dsts.done) begin
					res_cond <= dsts.result;
					res_high <= dsts.high;
					res_status <= ST_MEASURED;
					res_cal <= cal_q;
					st_q <= S_DONE;
				end
				S_CHECK: begin
					res_cond <= '0;
					res_high <= 1'b0;
					unique case (cmd_q)
						CMD_ENTER: begin
							cal_q <= 1'b1; res_cal <= 1'b1;
							pend_low_q <= k_low; pend_high_q <= k_high;
							res_status <= ST_ENTERED;
							st_q <= S_DONE;
						end
						CMD_EXIT: begin
							if (cal_q) begin
								k_low <= pend_low_q; k_high <= pend_high_q;
								res_status <= ST_SAVED;
							end else res_status <= ST_EXIT_IDLE;
							cal_q <= 1'b0; res_cal <= 1'b0;
							st_q <= S_DONE;
						end
						default: begin
							res_cal <= cal_q;
							if (!cal_q) begin
								res_status <= ST_NOT_CAL;
								st_q <= S_DONE;
							end else if (cal_go) begin
								res_status <= dsts.in_low_win ? ST_LOW_BUF : ST_HIGH_BUF;
								st_q <= S_CALDIV;
							end else begin
								res_status <= ST_UNKNOWN_BUF;
								st_q <= S_DONE;
							end
						end
					endcase
				end
				S_CALDIV: if (dsts.done) begin
					if (res_status == ST_LOW_BUF) pend_low_q <= dsts.result;
					else pend_high_q <= dsts.result;
					st_q <= S_DONE;
				end
				S_DONE: if (out_free) begin
					res_valid <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

[hdl/conductivity_compensate_calibrate_top.sv]
// Conductivity compensation and calibration, top level.
// Enter, exit and a calibrate that computes no constant are handled in the controller
// alone; measure and a calibrate inside a window also run the 64-step serial divider.
// One item at a time: s_tready stays low while busy and rises again in the same cycle
// as the internal result strobe res_valid, unless the output is stalled.
// arst_n clears state; constants reset to 1.0, calibration mode off.
module conductivity_compensate_calibrate_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [22:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata, // command[1:0], probe_voltage[17:2], temperature[29:18]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata // conductivity, status, high_range_used, in_calibration, k_low_out, k_high_out
);
	import ccc_pkg::*;

	dp_cmd_t dcmd;
	dp_sts_t dsts;
	logic busy, res_valid, res_high, res_cal, in_fire;
	logic [CONDW-1:0] res_cond;
	logic [2:0] res_status;
	logic [KW-1:0] k_low, k_high;
	logic [1:0] in_cmd;
	logic [KW-1:0] kl_q, kh_q;
	logic [CONDW-1:0] cond_q;
	logic [2:0] stat_q;
	logic hi_q, cal_q;
	logic [VW-1:0] pv_q;
	logic [TW-1:0] pt_q;

	assign in_cmd = s_tdata[1:0];
	assign s_tready = !busy;
	assign in_fire = s_tvalid && s_tready;

	// Operands are held for the second datapath launch of a calibrate item.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pv_q <= s_tdata[17:2];
			pt_q <= s_tdata[29:18];
		end
	end

	ccc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_fire(in_fire), .in_cmd(in_cmd), .busy(busy),
		.dcmd(dcmd), .dsts(dsts), .res_valid(res_valid), .res_cond(res_cond),
		.res_status(res_status), .res_high(res_high), .res_cal(res_cal),
		.k_low(k_low), .k_high(k_high), .out_free(!m_tvalid || m_tready)
	);

	ccc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(dcmd),
		.voltage(in_fire ? s_tdata[17:2] : pv_q),
		.temp(in_fire ? s_tdata[29:18] : pt_q),
		.k_low(k_low), .k_high(k_high), .sts(dsts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (res_valid) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			cond_q <= res_cond;
			stat_q <= res_status;
			hi_q <= res_high;
			cal_q <= res_cal;
			kl_q <= k_low;
			kh_q <= k_high;
		end
	end

	assign m_tdata = {3'b000, kh_q, kl_q, cal_q, hi_q, stat_q, cond_q};

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !$past(res_valid)) else $error("double result");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready) else $error("accept while busy");
	a_cond_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && stat_q != ST_MEASURED |-> cond_q == '0) else $error("nonzero cond");
endmodule
